FILE: hw/rtl/tli_pkg.sv
// ----------------------------------------------------------------------------
// tli_pkg: shared definitions for the table linear interpolator
// Command and status codes, field widths and the quotient type passed from
// the serial divider to the sequencer.
// ----------------------------------------------------------------------------
package tli_pkg;

	localparam int TABLE_DEPTH_DEF = 256;

	localparam int FUNC_W  = 2;
	localparam int FREQ_W  = 32;
	localparam int LEVEL_W = 16;
	localparam int STAT_W  = 2;

	// quotient magnitude bits kept; anything at or above 2^QUOT_W saturates
	localparam int QUOT_W = 18;
	localparam int NUM_W  = FREQ_W + LEVEL_W;

	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_REWIND = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd3;

	localparam logic [STAT_W-1:0] STAT_INTERP = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BELOW  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_ABOVE  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_SMALL  = 2'd3;

	localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = {1'b0, {(LEVEL_W-1){1'b1}}};
	localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = {1'b1, {(LEVEL_W-1){1'b0}}};

	typedef struct packed {
		logic              ovf;
		logic [QUOT_W-1:0] mag;
	} quot_t;

endpackage

FILE: hw/rtl/tli_table.sv
// ----------------------------------------------------------------------------
// tli_table: point store
// Frequency and level arrays with one write port and one registered read
// port; each port addresses both arrays at once.
// ----------------------------------------------------------------------------
module tli_table import tli_pkg::*; #(
	parameter int DEPTH = TABLE_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [FREQ_W-1:0]         wr_freq,
	input  logic signed [LEVEL_W-1:0] wr_level,
	input  logic [AW-1:0]             rd_addr,
	output logic [FREQ_W-1:0]         rd_freq,
	output logic signed [LEVEL_W-1:0] rd_level
);

	logic [FREQ_W-1:0]         freq_mem [DEPTH];
	logic signed [LEVEL_W-1:0] level_mem [DEPTH];

	// write one point per beat
	always_ff @(posedge clk) begin
		if (wr_en) begin
			freq_mem[wr_addr]  <= wr_freq;
			level_mem[wr_addr] <= wr_level;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rd_freq  <= freq_mem[rd_addr];
		rd_level <= level_mem[rd_addr];
	end

endmodule

FILE: hw/rtl/tli_div.sv
// ----------------------------------------------------------------------------
// tli_div: serial rounding divider
// Computes (2*num + den) / (2*den) one quotient bit per cycle, restoring
// form, with one extra leading step that flags a quotient too big to keep.
// ----------------------------------------------------------------------------
module tli_div import tli_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  num,
	input  logic [FREQ_W-1:0] den,
	output logic              busy,
	output quot_t             quot
);

	localparam int REM_W = NUM_W + 2;
	localparam int DSR_W = FREQ_W + 1 + QUOT_W;
	localparam int CNT_W = $clog2(QUOT_W + 1);

	logic [REM_W-1:0]  rem_q;
	logic [DSR_W-1:0]  dsr_q;
	logic [QUOT_W:0]   quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic [DSR_W-1:0]  rem_ext;
	logic [DSR_W-1:0]  diff;
	logic              ge;

	// trial subtract of the shifted divisor
	always_comb begin
		rem_ext = {{(DSR_W-REM_W){1'b0}}, rem_q};
		ge      = rem_ext >= dsr_q;
		diff    = rem_ext - dsr_q;
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(QUOT_W);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// remainder, divisor and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= REM_W'({num, 1'b0}) + REM_W'(den);
			dsr_q <= {den, 1'b0, {QUOT_W{1'b0}}};
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= diff[REM_W-1:0];
			end
			dsr_q <= dsr_q >> 1;
			quo_q <= {quo_q[QUOT_W-1:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quot.ovf = quo_q[QUOT_W];
	assign quot.mag = quo_q[QUOT_W-1:0];

endmodule

FILE: hw/rtl/table_linear_interpolator.sv
// ----------------------------------------------------------------------------
// table_linear_interpolator: piecewise linear lookup over a loaded table
// Points are appended in ascending frequency; queries return the level on
// the segment that brackets them, saturated to signed Q8.8.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid/item_ready, func/freq/level) takes clear,
//   append, rewind and query commands. Clear, append and rewind finish in
//   the accept cycle and give no result beat; item_ready stays high.
//   A query drops item_ready while the sequencer works. It walks the table
//   forward from the last segment used, with one table read and one compare
//   for each segment stepped over, then reads the segment ends, forms the
//   product in the 16x32 multiplier and runs the serial divider. A table
//   with fewer than two points skips all of this and answers from the final
//   state. One query is in work at a time.
//   Result channel (result_valid/result_ready, query_freq/result_level/
//   status) is driven from an output register: the next item is taken while
//   a result waits, and a query that finishes while the register is full
//   holds in its last state until result_ready frees it.
//   Reset empties the table and rewinds the search; no clearing pass runs.
// ----------------------------------------------------------------------------
module table_linear_interpolator import tli_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  logic [FUNC_W-1:0]         func,
	input  logic [FREQ_W-1:0]         freq,
	input  logic signed [LEVEL_W-1:0] level,
	output logic                      result_valid,
	input  logic                      result_ready,
	output logic [FREQ_W-1:0]         query_freq,
	output logic signed [LEVEL_W-1:0] result_level,
	output logic [STAT_W-1:0]         status
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = IW + 1;
	localparam int SW = 4;

	localparam logic [SW-1:0] ST_IDLE     = 4'd0;
	localparam logic [SW-1:0] ST_WALK_RD  = 4'd1;
	localparam logic [SW-1:0] ST_WALK_CMP = 4'd2;
	localparam logic [SW-1:0] ST_LD0      = 4'd3;
	localparam logic [SW-1:0] ST_LD1      = 4'd4;
	localparam logic [SW-1:0] ST_LD2      = 4'd5;
	localparam logic [SW-1:0] ST_PREP     = 4'd6;
	localparam logic [SW-1:0] ST_MUL      = 4'd7;
	localparam logic [SW-1:0] ST_DIV_GO   = 4'd8;
	localparam logic [SW-1:0] ST_DIV_WAIT = 4'd9;
	localparam logic [SW-1:0] ST_FIN      = 4'd10;

	logic [SW-1:0]              state_q;
	logic [CW-1:0]              count_q;
	logic [IW-1:0]              seg_q;
	logic [IW-1:0]              s_q;
	logic [IW-1:0]              last_q;
	logic [FREQ_W-1:0]          x_q;
	logic [FREQ_W-1:0]          f0_q;
	logic [FREQ_W-1:0]          f1_q;
	logic signed [LEVEL_W-1:0]  l0_q;
	logic signed [LEVEL_W-1:0]  l1_q;
	logic [LEVEL_W-1:0]         dlmag_q;
	logic [FREQ_W-1:0]          dxmag_q;
	logic [FREQ_W-1:0]          dmag_q;
	logic                       neg_q;
	logic                       eq_q;
	logic                       small_q;
	logic [STAT_W-1:0]          stat_q;
	logic [NUM_W-1:0]           num_q;
	logic                       out_valid_q;
	logic [FREQ_W-1:0]          out_freq_q;
	logic signed [LEVEL_W-1:0]  out_level_q;
	logic [STAT_W-1:0]          out_stat_q;

	logic                       accept;
	logic                       wr_en;
	logic [IW-1:0]              rd_addr;
	logic [FREQ_W-1:0]          rd_freq;
	logic signed [LEVEL_W-1:0]  rd_level;
	logic                       div_start;
	logic                       div_busy;
	quot_t                      quot;
	logic                       out_free;
	logic [IW-1:0]              last_new;

	logic signed [FREQ_W:0]     dx;
	logic signed [FREQ_W:0]     dd;
	logic signed [LEVEL_W:0]    dl;
	logic [FREQ_W:0]            dx_abs;
	logic [FREQ_W:0]            dd_abs;
	logic [LEVEL_W:0]           dl_abs;
	logic [STAT_W-1:0]          stat_new;

	logic signed [LEVEL_W+3:0]  sum;
	logic signed [LEVEL_W-1:0]  res;

	assign accept    = item_valid && item_ready;
	assign wr_en     = accept && (func == FUNC_APPEND) && (count_q != CW'(TABLE_DEPTH));
	assign rd_addr   = (state_q == ST_LD0) ? s_q : s_q + 1'b1;
	assign div_start = (state_q == ST_DIV_GO);
	assign out_free  = !out_valid_q || result_ready;
	assign last_new  = IW'(count_q - CW'(2));

	tli_table #(
		.DEPTH (TABLE_DEPTH),
		.AW    (IW)
	) u_table (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (count_q[IW-1:0]),
		.wr_freq  (freq),
		.wr_level (level),
		.rd_addr  (rd_addr),
		.rd_freq  (rd_freq),
		.rd_level (rd_level)
	);

	tli_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (dmag_q),
		.busy   (div_busy),
		.quot   (quot)
	);

	// segment differences, magnitudes, sign and status
	always_comb begin
		dx     = $signed({1'b0, x_q}) - $signed({1'b0, f0_q});
		dd     = $signed({1'b0, f1_q}) - $signed({1'b0, f0_q});
		dl     = $signed({l1_q[LEVEL_W-1], l1_q}) - $signed({l0_q[LEVEL_W-1], l0_q});
		dx_abs = dx[FREQ_W] ? (FREQ_W+1)'(-dx) : dx;
		dd_abs = dd[FREQ_W] ? (FREQ_W+1)'(-dd) : dd;
		dl_abs = dl[LEVEL_W] ? (LEVEL_W+1)'(-dl) : dl;
		if (x_q < f0_q) begin
			stat_new = STAT_BELOW;
		end else if ((f1_q >= f0_q) && (x_q > f1_q)) begin
			stat_new = STAT_ABOVE;
		end else begin
			stat_new = STAT_INTERP;
		end
	end

	// add the signed quotient to the lower level and saturate
	always_comb begin
		if (neg_q) begin
			sum = $signed({{4{l0_q[LEVEL_W-1]}}, l0_q}) - $signed({2'b00, quot.mag});
		end else begin
			sum = $signed({{4{l0_q[LEVEL_W-1]}}, l0_q}) + $signed({2'b00, quot.mag});
		end
		if (small_q) begin
			res = '0;
		end else if (eq_q) begin
			res = l0_q;
		end else if (quot.ovf) begin
			res = neg_q ? LEVEL_MIN : LEVEL_MAX;
		end else if (sum > $signed({{4{LEVEL_MAX[LEVEL_W-1]}}, LEVEL_MAX})) begin
			res = LEVEL_MAX;
		end else if (sum < $signed({{4{LEVEL_MIN[LEVEL_W-1]}}, LEVEL_MIN})) begin
			res = LEVEL_MIN;
		end else begin
			res = sum[LEVEL_W-1:0];
		end
	end

	// sequencer and table bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			seg_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (func)
							FUNC_CLEAR: begin
								count_q <= '0;
								seg_q   <= '0;
							end
							FUNC_APPEND: begin
								if (wr_en) begin
									count_q <= count_q + 1'b1;
								end
							end
							FUNC_REWIND: begin
								seg_q <= '0;
							end
							default: begin
								if (count_q < CW'(2)) begin
									state_q <= ST_FIN;
								end else begin
									state_q <= ST_WALK_RD;
								end
							end
						endcase
					end
				end
				ST_WALK_RD: begin
					state_q <= (s_q == last_q) ? ST_LD0 : ST_WALK_CMP;
				end
				ST_WALK_CMP: begin
					state_q <= (rd_freq <= x_q) ? ST_WALK_RD : ST_LD0;
				end
				ST_LD0: begin
					seg_q   <= s_q;
					state_q <= ST_LD1;
				end
				ST_LD1: begin
					state_q <= ST_LD2;
				end
				ST_LD2: begin
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					state_q <= (f1_q == f0_q) ? ST_FIN : ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_DIV_GO;
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (!div_busy) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// query working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q     <= freq;
				small_q <= count_q < CW'(2);
				stat_q  <= STAT_SMALL;
				last_q  <= last_new;
				s_q     <= (seg_q > last_new) ? last_new : seg_q;
			end
			ST_WALK_CMP: begin
				if (rd_freq <= x_q) begin
					s_q <= s_q + 1'b1;
				end
			end
			ST_LD1: begin
				f0_q <= rd_freq;
				l0_q <= rd_level;
			end
			ST_LD2: begin
				f1_q <= rd_freq;
				l1_q <= rd_level;
			end
			ST_PREP: begin
				dxmag_q <= dx_abs[FREQ_W-1:0];
				dmag_q  <= dd_abs[FREQ_W-1:0];
				dlmag_q <= dl_abs[LEVEL_W-1:0];
				neg_q   <= dx[FREQ_W] ^ dd[FREQ_W] ^ dl[LEVEL_W];
				eq_q    <= f1_q == f0_q;
				stat_q  <= stat_new;
			end
			ST_MUL: begin
				num_q <= NUM_W'(dlmag_q) * NUM_W'(dxmag_q);
			end
			default: begin
			end
		endcase
	end

	// result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			out_freq_q  <= x_q;
			out_level_q <= res;
			out_stat_q  <= stat_q;
		end
	end

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = out_valid_q;
	assign query_freq   = out_freq_q;
	assign result_level = out_level_q;
	assign status       = out_stat_q;

endmodule

FILE: hw/rtl/tli_checker.sv
// ----------------------------------------------------------------------------
// tli_checker: port-level checks for the table linear interpolator
// Watches the item and result channels and flags sequencing slips.
// ----------------------------------------------------------------------------
module tli_checker import tli_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	input  logic                      item_ready,
	input  logic [FUNC_W-1:0]         func,
	input  logic                      result_valid,
	input  logic                      result_ready,
	input  logic [FREQ_W-1:0]         query_freq,
	input  logic signed [LEVEL_W-1:0] result_level,
	input  logic [STAT_W-1:0]         status
);

	// a waiting result beat holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(query_freq) && $stable(result_level) && $stable(status))
		else $error("result beat changed while stalled");

	// a query occupies the sequencer
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (func == FUNC_QUERY) |=> !item_ready)
		else $error("item taken while a query is in work");

	// table commands finish at once
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (func != FUNC_QUERY) |=> item_ready)
		else $error("table command stalled the item channel");

	// a short table answers with level zero
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == STAT_SMALL) |-> (result_level == '0))
		else $error("nonzero level for a short table");

	// a new result frees the item channel
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> item_ready)
		else $error("item channel not free after a result");

endmodule

bind table_linear_interpolator tli_checker u_tli_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.func         (func),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.query_freq   (query_freq),
	.result_level (result_level),
	.status       (status)
);

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the table linear interpolator
// Loads point tables, sends ascending and out-of-order queries with rewinds,
// and checks every result beat against a local interpolation predictor.
// Directed corner rows come first, then random load-and-query sessions, all
// under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
	import tli_pkg::*;

	localparam int DEPTH        = TABLE_DEPTH_DEF;
	localparam int RANDOM_BEATS = 850;
	localparam int HOLD_CYCLES  = 400;
	localparam int IDLE_LIMIT   = 20000;
	localparam int NUM_DIRECTED = 25;

	typedef struct packed {
		logic [FREQ_W-1:0]         qfreq;
		logic signed [LEVEL_W-1:0] lvl;
		logic [STAT_W-1:0]         st;
	} level_beat_t;

	typedef struct packed {
		logic [FUNC_W-1:0]         fn;
		logic [FREQ_W-1:0]         fq;
		logic signed [LEVEL_W-1:0] lv;
		logic                      typed;
		logic signed [LEVEL_W-1:0] t_lvl;
		logic [STAT_W-1:0]         t_st;
	} dir_row_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_EVERY4, RX_SPARSE} rx_mode_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      item_valid;
	logic                      item_ready;
	logic [FUNC_W-1:0]         func;
	logic [FREQ_W-1:0]         freq;
	logic signed [LEVEL_W-1:0] level;
	logic                      result_valid;
	logic                      result_ready;
	logic [FREQ_W-1:0]         query_freq;
	logic signed [LEVEL_W-1:0] result_level;
	logic [STAT_W-1:0]         status;

	// predictor state
	logic [FREQ_W-1:0]         tbl_freq  [DEPTH];
	logic signed [LEVEL_W-1:0] tbl_level [DEPTH];
	int unsigned               tbl_count;
	int unsigned               seg_pos;

	level_beat_t pending_levels[$];
	int          mismatches;
	int          beats_sent;
	int          burst_left;
	bit          drain_pending;
	int          hold_reqs;
	int          holds_done;
	int          hold_cnt;
	int          rx_phase_left;
	rx_mode_t    rx_mode;
	int unsigned rx_cyc;
	int          idle_cycles;

	// corner rows; typed expectations only where obvious
	dir_row_t directed_rows [0:NUM_DIRECTED-1] = '{
		{FUNC_QUERY,  32'd0,          16'sh0000, 1'b1, 16'sh0000, STAT_SMALL},
		{FUNC_APPEND, 32'd100,        16'sh0100, 1'b0, 16'sh0000, STAT_INTERP},
		{FUNC_APPEND, 32'd200,        16'sh0300, 1'b0, 16'sh0000, STAT_INTERP},
		{FUNC_QUERY,  32'd150,        16'sh5a5a, 1'b1, 16'sh0200, STAT_INTERP},
		{FUNC_QUERY,  32'd50,         16'sha5a5, 1'b0, 16'sh0000, STAT_INTERP},
		{FUNC_QUERY,  32'hffff_ffff,  16'sh0000, 1'b1, LEVEL_MAX, STAT_ABOVE},
		{FUNC_APPEND, 32'd200,        LEVEL_MIN, 1'b0, 16'sh0000, STAT_INTERP},
		{FUNC_QUERY,  32'd200,        16'sh0000, 1'b1, 16'sh0300, STAT_INTERP},
		{FUNC_QUERY,  32'd250,        16'sh0000, 1'b0, 16'sh0000, STAT_INTERP},
		{FUNC_QUERY,  32'd120,        16'sh0000, 1'b0, 16'sh0000, STAT_INTERP},
		{FUNC_REWIND, 32'h5555_aaaa,  16'sh7fff, 1'b0, 16'sh0000, STAT_INTERP},
		{FUNC_QUERY,  32'd120,        16'sh0000, 1'b0, 16'sh0000, STAT_INTERP},
		{FUNC_APPEND, 32'd0,          LEVEL_MAX, 1'b0, 16'sh0000, STAT_INTERP},
		{FUNC_QUERY,  32'd1000,       16'sh0000, 1'b0, 16'sh0000, STAT_INTERP},
		{FUNC_CLEAR,  32'haaaa_5555,  16'sh8000, 1'b0, 16'sh0000, STAT_INTERP},
		{FUNC_APPEND, 32'd0,          LEVEL_MIN, 1'b0, 16'sh0000, STAT_INTERP},
		{FUNC_APPEND, 32'hffff_ffff,  LEVEL_MAX, 1'b0, 16'sh0000, STAT_INTERP},
		{FUNC_QUERY,  32'd0,          16'sh0000, 1'b1, LEVEL_MIN, STAT_INTERP},
		{FUNC_QUERY,  32'hffff_ffff,  16'sh0000, 1'b1, LEVEL_MAX, STAT_INTERP},
		{FUNC_CLEAR,  32'd0,          16'sh0000, 1'b0, 16'sh0000, STAT_INTERP},
		{FUNC_QUERY,  32'd5,          16'sh0000, 1'b1, 16'sh0000, STAT_SMALL},
		{FUNC_APPEND, 32'd1000,       LEVEL_MAX, 1'b0, 16'sh0000, STAT_INTERP},
		{FUNC_APPEND, 32'd1001,       LEVEL_MIN, 1'b0, 16'sh0000, STAT_INTERP},
		{FUNC_QUERY,  32'd5000,       16'sh0000, 1'b1, LEVEL_MIN, STAT_ABOVE},
		{FUNC_QUERY,  32'd0,          16'sh0000, 1'b1, LEVEL_MAX, STAT_BELOW}
	};

	table_linear_interpolator i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.func         (func),
		.freq         (freq),
		.level        (level),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.query_freq   (query_freq),
		.result_level (result_level),
		.status       (status)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Apply one command to the predictor; return 1 with the level beat for a query
	function automatic bit interp_predict(input logic [FUNC_W-1:0] fn,
			input logic [FREQ_W-1:0] fq, input logic signed [LEVEL_W-1:0] lv,
			output level_beat_t r);
		int unsigned s;
		int unsigned last;
		longint      x, f0, f1, l0, l1, num, den, mag, q, acc;
		bit          neg;
		r = '0;
		case (fn)
		FUNC_CLEAR: begin
			tbl_count = 0;
			seg_pos   = 0;
			return 1'b0;
		end
		FUNC_APPEND: begin
			if (tbl_count < DEPTH) begin
				tbl_freq[tbl_count]  = fq;
				tbl_level[tbl_count] = lv;
				tbl_count++;
			end
			return 1'b0;
		end
		FUNC_REWIND: begin
			seg_pos = 0;
			return 1'b0;
		end
		default: ;
		endcase

		r.qfreq = fq;
		if (tbl_count < 2) begin
			r.lvl = '0;
			r.st  = STAT_SMALL;
			return 1'b1;
		end

		// walk forward only, never past the last segment
		last = tbl_count - 2;
		s    = (seg_pos > last) ? last : seg_pos;
		while (s < last && tbl_freq[s+1] <= fq)
			s++;
		seg_pos = s;

		x  = {32'd0, fq};
		f0 = {32'd0, tbl_freq[s]};
		f1 = {32'd0, tbl_freq[s+1]};
		l0 = tbl_level[s];
		l1 = tbl_level[s+1];

		if (x < f0)
			r.st = STAT_BELOW;
		else if (x > f1 && f1 >= f0)
			r.st = STAT_ABOVE;
		else if (x > f0 && f1 == f0)
			r.st = STAT_ABOVE;
		else
			r.st = STAT_INTERP;

		// equal ends give the lower point; else round half away from zero
		if (f1 == f0) begin
			acc = l0;
		end else begin
			num = (l1 - l0) * (x - f0);
			den = f1 - f0;
			if (den < 0) begin
				den = -den;
				num = -num;
			end
			neg = (num < 0);
			mag = neg ? -num : num;
			q   = (mag * 2 + den) / (2 * den);
			acc = l0 + (neg ? -q : q);
		end

		if (acc > 32767)
			r.lvl = LEVEL_MAX;
		else if (acc < -32768)
			r.lvl = LEVEL_MIN;
		else
			r.lvl = acc[LEVEL_W-1:0];
		return 1'b1;
	endfunction

	// Offer one beat, honouring bursts, gaps and a requested drain
	task automatic offer_beat(input logic [FUNC_W-1:0] fn, input logic [FREQ_W-1:0] fq,
			input logic signed [LEVEL_W-1:0] lv, input bit typed,
			input logic signed [LEVEL_W-1:0] t_lvl, input logic [STAT_W-1:0] t_st);
		level_beat_t r;
		if (drain_pending) begin
			drain_pending = 1'b0;
			item_valid <= 1'b0;
			do @(posedge clk); while (pending_levels.size() != 0);
		end else if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
			                                          : $urandom_range(1, 16);
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		burst_left--;

		item_valid <= 1'b1;
		func       <= fn;
		freq       <= fq;
		level      <= lv;
		do @(posedge clk); while (!item_ready);
		beats_sent++;

		if (interp_predict(fn, fq, lv, r)) begin
			if (typed) begin
				r.lvl = t_lvl;
				r.st  = t_st;
			end
			pending_levels.push_back(r);
		end
	endtask

	task automatic offer(input logic [FUNC_W-1:0] fn, input logic [FREQ_W-1:0] fq,
			input logic signed [LEVEL_W-1:0] lv);
		offer_beat(fn, fq, lv, 1'b0, '0, STAT_INTERP);
	endtask

	// One session: clear, load a table, then sweep queries upward (or, now and then, pure noise)
	task automatic run_session(input int idx);
		int                        npts;
		int                        nq;
		int                        pick;
		longint                    step_max;
		longint                    fcur;
		longint                    first_f;
		longint                    qcur;
		longint                    qstep_max;
		longint                    margin;
		logic signed [LEVEL_W-1:0] lcur;
		logic [FREQ_W-1:0]         pf;
		bit                        big;

		// pure noise now and then
		if (idx > 6 && $urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(5, 20))
				offer(2'($urandom_range(0, 3)), $urandom, 16'($urandom));
			return;
		end

		big = (idx == 2);
		offer(FUNC_CLEAR, $urandom, 16'($urandom));

		case ($urandom_range(0, 3))
		0:       step_max = 4;
		1:       step_max = 1000;
		2:       step_max = 64'd1 << 20;
		default: step_max = 64'd1 << 27;
		endcase
		if (big) begin
			npts     = DEPTH + 3;
			step_max = 1000;
		end else if ($urandom_range(0, 9) == 0) begin
			npts = $urandom_range(0, 1);
		end else begin
			npts = $urandom_range(2, 24);
		end

		fcur    = ($urandom_range(0, 7) == 0) ? longint'($urandom)
		                                       : longint'($urandom_range(0, 100000));
		first_f = fcur;
		lcur    = 16'($urandom);
		for (int i = 0; i < npts; i++) begin
			// mostly ascending; a stray point now and then
			if (!big && $urandom_range(0, 29) == 0) begin
				pf = $urandom;
			end else begin
				if (i > 0)
					fcur = fcur + longint'($urandom_range(0, 32'(step_max)));
				if (fcur > 64'hffff_ffff)
					fcur = 64'hffff_ffff;
				pf = fcur[FREQ_W-1:0];
			end
			if ($urandom_range(0, 7) == 0)
				lcur = 16'($urandom);
			else
				lcur = lcur + 16'(int'($urandom_range(0, 4000)) - 2000);
			offer(FUNC_APPEND, pf, lcur);
		end

		nq = big ? 8 : $urandom_range(3, 30);
		if (idx == 4) begin
			// long receiver hold while queries keep coming
			nq = 40;
			hold_reqs++;
		end

		margin    = longint'($urandom_range(0, 32'(step_max)));
		qcur      = (first_f > margin) ? first_f - margin : 0;
		qstep_max = (fcur - first_f) / nq * 2 + 2;
		if (qstep_max > 64'hffff_ffff)
			qstep_max = 64'hffff_ffff;
		for (int i = 0; i < nq; i++) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				offer(FUNC_REWIND, $urandom, 16'($urandom));
				qcur = (first_f > margin) ? first_f - margin : 0;
			end else if (pick == 1) begin
				offer(FUNC_QUERY, $urandom, 16'($urandom));
			end else begin
				offer(FUNC_QUERY, qcur[FREQ_W-1:0], 16'($urandom));
				qcur = qcur + longint'($urandom_range(0, 32'(qstep_max)));
				if (qcur > 64'hffff_ffff)
					qcur = 64'hffff_ffff;
			end
		end
	endtask

	// Result checker: compare each accepted beat with the oldest prediction
	always @(posedge clk) begin
		level_beat_t exp_beat;
		if (arst_n && result_valid && result_ready) begin
			if (pending_levels.size() == 0) begin
				$error("result beat with no query outstanding: query_freq %0d", query_freq);
				mismatches++;
			end else begin
				exp_beat = pending_levels.pop_front();
				if (query_freq !== exp_beat.qfreq) begin
					$error("query_freq: expected %0d, got %0d", exp_beat.qfreq, query_freq);
					mismatches++;
				end
				if (result_level !== exp_beat.lvl) begin
					$error("result_level: expected %0d, got %0d", exp_beat.lvl,
						result_level);
					mismatches++;
				end
				if (status !== exp_beat.st) begin
					$error("status: expected %0d, got %0d", exp_beat.st, status);
					mismatches++;
				end
			end
		end
	end

	// Receiver: random stall pattern, with a long hold when requested
	always @(posedge clk) begin
		rx_cyc++;
		if (hold_cnt > 0) begin
			hold_cnt--;
			result_ready <= 1'b0;
		end else if (hold_reqs != holds_done) begin
			holds_done++;
			hold_cnt = HOLD_CYCLES;
			result_ready <= 1'b0;
		end else begin
			if (rx_phase_left <= 0) begin
				rx_mode       = rx_mode_t'($urandom_range(0, 3));
				rx_phase_left = $urandom_range(16, 200);
			end
			rx_phase_left--;
			case (rx_mode)
			RX_OPEN:   result_ready <= 1'b1;
			RX_COIN:   result_ready <= 1'($urandom_range(0, 1));
			RX_EVERY4: result_ready <= (rx_cyc % 4 == 0);
			default:   result_ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL table_linear_interpolator");
				$finish;
			end
		end
	end

	// Stimulus: reset, directed rows, random sessions, then drain
	initial begin
		int sess;
		arst_n        = 1'b0;
		item_valid    = 1'b0;
		func          = FUNC_CLEAR;
		freq          = '0;
		level         = '0;
		result_ready  = 1'b0;
		tbl_count     = 0;
		seg_pos       = 0;
		mismatches    = 0;
		beats_sent    = 0;
		burst_left    = 0;
		drain_pending = 1'b0;
		hold_reqs     = 0;
		holds_done    = 0;
		hold_cnt      = 0;
		rx_phase_left = 0;
		rx_mode       = RX_OPEN;
		rx_cyc        = 0;
		idle_cycles   = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			offer_beat(directed_rows[i].fn, directed_rows[i].fq, directed_rows[i].lv,
				directed_rows[i].typed, directed_rows[i].t_lvl, directed_rows[i].t_st);

		sess = 0;
		while (beats_sent < NUM_DIRECTED + RANDOM_BEATS) begin
			// pause the sender until every answer is back
			if (sess == 6 || $urandom_range(0, 5) == 0)
				drain_pending = 1'b1;
			run_session(sess);
			sess++;
		end

		item_valid <= 1'b0;
		while (pending_levels.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);

		if (mismatches == 0)
			$display("PASS table_linear_interpolator");
		else
			$display("FAIL table_linear_interpolator");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/tli_pkg.sv
hw/rtl/tli_table.sv
hw/rtl/tli_div.sv
hw/rtl/table_linear_interpolator.sv
hw/rtl/tli_checker.sv
dv/tb_top.sv
